// ----- src/mpti_pkg.sv -----
`timescale 1ns / 1ps
package mpti_pkg;
  localparam int W = 32;
  localparam int CW = $clog2(W);

  typedef struct packed {
    logic [W-1:0] base;
    logic [W-1:0] exponent;
    logic [W-1:0] divisor;
    logic [W-1:0] modulus;
  } in_word_t;

  typedef struct packed {
    logic [W-1:0] result;
    logic         no_inverse;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } op_t;

  typedef struct packed {
    logic         start;
    op_t          op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] m;
  } unit_req_t;

  typedef struct packed {
    logic         done;
    logic [W-1:0] res;
    logic [W-1:0] rem;
  } unit_rsp_t;
endpackage

// ----- src/mpti_if.sv -----
`timescale 1ns / 1ps
interface mpti_in_if;
  import mpti_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

interface mpti_out_if;
  import mpti_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// ----- src/mpti_unit.sv -----
`timescale 1ns / 1ps
// Bit-serial unit: OP_MUL gives a*b mod m (a, b < m, one bit a cycle);
// OP_DIV gives a / b and a % b by restoring division, one bit a cycle.
module mpti_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  mpti_pkg::unit_req_t  req,
  output mpti_pkg::unit_rsp_t  rsp
);
  import mpti_pkg::*;

  logic         busy;
  logic         done;
  op_t          op;
  logic [CW-1:0] cnt;
  logic [W-1:0] a, b, m, acc, q;
  logic [W:0]   d2, s2, r2;
  logic [W-1:0] dbl, sum;

  always_comb begin
    d2  = {acc, 1'b0};
    dbl = (d2 >= {1'b0, m}) ? W'(d2 - {1'b0, m}) : acc << 1;
    s2  = {1'b0, dbl} + {1'b0, a};
    sum = b[W-1] ? ((s2 >= {1'b0, m}) ? W'(s2 - {1'b0, m}) : s2[W-1:0]) : dbl;
    r2  = {acc, q[W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        done <= 1'b0;
        busy <= 1'b1;
        op   <= req.op;
        a    <= req.a;
        b    <= req.b;
        q    <= req.a;
        m    <= req.m;
        acc  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (op == OP_MUL) begin
          acc <= sum;
          b   <= b << 1;
        end else begin
          if (r2 >= {1'b0, b}) begin
            acc <= W'(r2 - {1'b0, b});
            q   <= {q[W-2:0], 1'b1};
          end else begin
            acc <= r2[W-1:0];
            q   <= {q[W-2:0], 1'b0};
          end
        end
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.res  = (op == OP_MUL) ? acc : q;
    rsp.rem  = acc;
  end

  assert property (@(posedge clk) disable iff (rst) rsp.done |-> !busy)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("start lost");
  assert property (@(posedge clk) disable iff (rst) busy && req.start |-> 1'b0)
    else $error("start while busy");
endmodule

// ----- src/modular_power_times_inverse.sv -----
`timescale 1ns / 1ps
// channel | dir | payload
// in      | in  | base, exponent, divisor, modulus
// out     | out | result, no_inverse
// Each word runs through one bit-serial unit, one operation at a time:
// divisor reduction, up to ~46 Euclid steps (a division and a multiply
// each), base reduction, up to 32 multiplies and 31 squarings, one final
// multiply. Modulus 0 or 1 goes straight to the output.
// Not ready while a word is at work or its result waits. Synchronous
// active-high reset clears control only.
module modular_power_times_inverse (
  input logic clk,
  input logic rst,
  mpti_in_if.sink    in_ch,
  mpti_out_if.source out_ch
);
  import mpti_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDIV  = 9'b000000010,
    S_EDIV  = 9'b000000100,
    S_EMUL  = 9'b000001000,
    S_RBASE = 9'b000010000,
    S_PMUL  = 9'b000100000,
    S_PSQ   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t        state;
  logic          issued;
  unit_req_t     req;
  unit_rsp_t     rsp;
  logic [W-1:0]  m, ex, sq, acc, r0, r1, t0, t1, qv, bs, dv;
  logic          flag;

  mpti_unit u_unit (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    req.start = 1'b0;
    req.op    = OP_MUL;
    req.a     = '0;
    req.b     = '0;
    req.m     = m;
    unique case (state)
      S_RDIV: begin
        req.start = !issued;
        req.op    = OP_DIV;
        req.a     = dv;
        req.b     = m;
      end
      S_EDIV: begin
        req.start = !issued;
        req.op    = OP_DIV;
        req.a     = r0;
        req.b     = r1;
      end
      S_EMUL: begin
        req.start = !issued;
        req.a     = t1;
        req.b     = qv;
      end
      S_RBASE: begin
        req.start = !issued;
        req.op    = OP_DIV;
        req.a     = bs;
        req.b     = m;
      end
      S_PMUL: begin
        req.start = !issued;
        req.a     = acc;
        req.b     = sq;
      end
      S_PSQ: begin
        req.start = !issued;
        req.a     = sq;
        req.b     = sq;
      end
      S_FIN: begin
        req.start = !issued;
        req.a     = acc;
        req.b     = t0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issued       <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (rsp.done) issued <= 1'b0;
      else if (req.start) issued <= 1'b1;
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          bs   <= in_ch.data.base;
          ex   <= in_ch.data.exponent;
          dv   <= in_ch.data.divisor;
          m    <= in_ch.data.modulus;
          acc  <= '0;
          flag <= (in_ch.data.modulus == '0);
          if (in_ch.data.modulus <= W'(1)) state <= S_OUT;
          else state <= S_RDIV;
        end
        S_RDIV: if (rsp.done) begin
          r0 <= m;
          r1 <= rsp.rem;
          t0 <= '0;
          t1 <= W'(1);
          if (rsp.rem == '0) begin
            flag  <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_EDIV;
          end
        end
        S_EDIV: if (rsp.done) begin
          qv    <= rsp.res;
          r0    <= r1;
          r1    <= rsp.rem;
          state <= S_EMUL;
        end
        S_EMUL: if (rsp.done) begin
          t0 <= t1;
          t1 <= (t0 >= rsp.res) ? t0 - rsp.res : m - (rsp.res - t0);
          if (r1 != '0) begin
            state <= S_EDIV;
          end else if (r0 == W'(1)) begin
            state <= S_RBASE;
          end else begin
            flag  <= 1'b1;
            state <= S_OUT;
          end
        end
        S_RBASE: if (rsp.done) begin
          sq  <= rsp.rem;
          acc <= W'(1);
          if (ex == '0) state <= S_FIN;
          else state <= ex[0] ? S_PMUL : S_PSQ;
        end
        S_PMUL: if (rsp.done) begin
          acc   <= rsp.res;
          state <= (ex[W-1:1] == '0) ? S_FIN : S_PSQ;
        end
        S_PSQ: if (rsp.done) begin
          sq    <= rsp.res;
          ex    <= ex >> 1;
          state <= ex[1] ? S_PMUL : S_PSQ;
        end
        S_FIN: if (rsp.done) begin
          acc   <= rsp.res;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.data  <= '{result: (flag ? '0 : acc), no_inverse: flag};
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output word dropped or changed while waiting");
  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> !out_ch.valid)
    else $error("ready while a result waits");
  assert property (@(posedge clk) disable iff (rst) rsp.done |-> issued)
    else $error("unit done without a request");
endmodule

// ----- tb/mpti_checker.sv -----
`timescale 1ns / 1ps
module mpti_checker (
  input  logic clk,
  input  logic rst,
  mpti_in_if.monitor   in_mon,
  mpti_out_if.monitor  out_mon,
  output int           fails,
  output int           pending
);
  import mpti_pkg::*;

  out_word_t answers_q[$];

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] p;
    p = a * b;
    return 64'(p % m);
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 1 % m;
    sq = b % m;
    for (int i = 0; i < W; i++) begin
      if (e[i]) acc = mulmod(acc, sq, m);
      sq = mulmod(sq, sq, m);
    end
    return acc;
  endfunction

  function automatic out_word_t power_over_divisor(in_word_t w);
    out_word_t o;
    logic [63:0] m, r0, r1, rn, q;
    logic signed [65:0] t0, t1, tn;
    m = w.modulus;
    o = '0;
    if (m == 0) begin
      o.no_inverse = 1'b1;
    end else if (m != 1) begin
      r0 = m;
      r1 = w.divisor % m;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        q = r0 / r1;
        rn = r0 - q * r1;
        tn = t0 - $signed({2'b0, q}) * t1;
        r0 = r1; r1 = rn; t0 = t1; t1 = tn;
      end
      if (r0 != 1) begin
        o.no_inverse = 1'b1;
      end else begin
        t0 = t0 % $signed({2'b0, m});
        if (t0 < 0) t0 = t0 + $signed({2'b0, m});
        o.result = W'(mulmod(powmod(w.base, w.exponent, m), 64'(t0), m));
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    out_word_t exp_w;
    int bad;
    bad = 0;
    if (rst) begin
      answers_q.delete();
      fails <= 0;
      pending <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        answers_q.push_back(power_over_divisor(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        if (answers_q.size() == 0) begin
          $error("result: expected no word, got %0h", out_mon.data.result);
          bad = bad + 1;
        end else begin
          exp_w = answers_q.pop_front();
          if (exp_w.result !== out_mon.data.result) begin
            $error("result: expected %0h, got %0h", exp_w.result, out_mon.data.result);
            bad = bad + 1;
          end
          if (exp_w.no_inverse !== out_mon.data.no_inverse) begin
            $error("no_inverse: expected %0b, got %0b", exp_w.no_inverse,
                   out_mon.data.no_inverse);
            bad = bad + 1;
          end
        end
      end
      fails <= fails + bad;
      pending <= answers_q.size();
    end
  end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import mpti_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int fails, pending;
  int cycles = 0;
  int idle_out = 0;

  mpti_in_if  in_ch ();
  mpti_out_if out_ch ();

  modular_power_times_inverse dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  mpti_checker chk (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
                    .fails(fails), .pending(pending));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 40000000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
      idle_out <= $urandom_range(0, 11);
    end else if (out_ch.valid && out_ch.ready) begin
      out_ch.ready <= 0;
      idle_out <= $urandom_range(0, 11);
    end else if (idle_out > 0) begin
      idle_out <= idle_out - 1;
    end else begin
      out_ch.ready <= 1;
    end
  end

  function automatic logic [31:0] pick();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 255);
      3: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [31:0] b, logic [31:0] e, logic [31:0] d, logic [31:0] m);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= '{base: b, exponent: e, divisor: d, modulus: m};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    logic [31:0] m;
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(5, 3, 7, 1);
    send(2, 0, 3, 7);
    send(0, 0, 1, 2);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFB);
    send(3, 5, 0, 10);
    send(3, 5, 4, 10);
    send(3, 5, 10, 10);
    send(7, 13, 3, 10);
    send(123, 456, 789, 1000003);
    send(0, 5, 3, 11);
    send(32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
    send(1, 1, 1, 32'hFFFF_FFFF);
    send(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAB);
    in_ch.valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    for (int i = 0; i < 1040; i++) begin
      m = pick();
      if (m == 0) m = 1;
      send(pick(), pick(), pick(), m);
      if (i == 500) begin
        in_ch.valid <= 0;
        @(posedge clk);
        wait (pending == 0);
      end
    end
    in_ch.valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/mpti_pkg.sv
src/mpti_if.sv
src/mpti_unit.sv
src/modular_power_times_inverse.sv
tb/mpti_checker.sv
tb/tb.sv
